/* hdl/khws_pkg.sv */
// ----------------------------------------------------------------------------
// khws_pkg: shared types, constants and mix functions
// Widths, queue sizing, back-end states and the one-at-a-time mix steps.
// ----------------------------------------------------------------------------
package khws_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned HASH_W      = 32;
	localparam int unsigned WC_W        = 9;
	localparam int unsigned IDX_W       = 8;
	localparam int unsigned MAX_WORKERS = 256;
	localparam int unsigned BIT_W       = $clog2(HASH_W);
	localparam int unsigned QDEPTH      = 2;
	localparam int unsigned QPTR_W      = $clog2(QDEPTH);
	localparam int unsigned QCNT_W      = $clog2(QDEPTH + 1);
	localparam int unsigned OUT_W       = IDX_W + HASH_W;

	typedef logic [HASH_W-1:0] hash_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_FIN,
		BK_DIV,
		BK_DONE
	} back_state_t;

	// status of the back end, watched at the top level
	typedef struct packed {
		logic            busy;
		logic [WC_W-1:0] rem;
		logic [WC_W-1:0] count;
	} back_status_t;

	function automatic hash_t mix_byte(input hash_t h, input logic [BYTE_W-1:0] b);
		hash_t h0;
		hash_t h1;
		hash_t h2;
		h0 = h + {{(HASH_W-BYTE_W){1'b0}}, b};
		h1 = h0 + (h0 << 10);
		h2 = h1 ^ (h1 >> 6);
		return h2;
	endfunction

	function automatic hash_t final_mix(input hash_t h);
		hash_t h1;
		hash_t h2;
		hash_t h3;
		h1 = h + (h << 3);
		h2 = h1 ^ (h1 >> 11);
		h3 = h2 + (h2 << 15);
		return h3;
	endfunction

	// zero counts as one, anything above the maximum saturates
	function automatic logic [WC_W-1:0] eff_count(input logic [WC_W-1:0] wc);
		logic [WC_W-1:0] n;
		n = wc;
		if (n == '0) begin
			n = WC_W'(1);
		end
		if (n > WC_W'(MAX_WORKERS)) begin
			n = WC_W'(MAX_WORKERS);
		end
		return n;
	endfunction

endpackage

/* hdl/khws_front.sv */
// ----------------------------------------------------------------------------
// khws_front: byte intake
// Mixes each key byte into the running value and pushes the unfinished hash
// of a completed key into the queue.
// ----------------------------------------------------------------------------
module khws_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [khws_pkg::BYTE_W-1:0] key_byte,
	input  logic                       last_byte,
	input  logic                       empty_key,
	input  logic                       q_full,
	output logic                       q_push,
	output khws_pkg::hash_t            q_data
);

	khws_pkg::hash_t running_q;
	khws_pkg::hash_t mixed;
	logic            accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign mixed    = khws_pkg::mix_byte(running_q, key_byte);
	assign q_push   = accept && (empty_key || last_byte);
	// empty key drops what was mixed; final mix of zero is zero
	assign q_data   = empty_key ? '0 : mixed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= '0;
		end else if (accept) begin
			if (empty_key || last_byte) begin
				running_q <= '0;
			end else begin
				running_q <= mixed;
			end
		end
	end

endmodule

/* hdl/khws_queue.sv */
// ----------------------------------------------------------------------------
// khws_queue: short queue between intake and finish
// Holds unfinished hashes of completed keys, first in first out.
// ----------------------------------------------------------------------------
module khws_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  khws_pkg::hash_t push_data,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output khws_pkg::hash_t pop_data
);

	khws_pkg::hash_t                 slot_q [khws_pkg::QDEPTH];
	logic [khws_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [khws_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [khws_pkg::QCNT_W-1:0]     count_q;
	logic                            do_push;
	logic                            do_pop;

	assign full     = (count_q == khws_pkg::QCNT_W'(khws_pkg::QDEPTH));
	assign valid    = (count_q != '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/khws_back.sv */
// ----------------------------------------------------------------------------
// khws_back: hash finish and worker selection
// Applies the final mix, reduces the hash modulo the worker count one bit per
// cycle and holds the result in an output register.
// ----------------------------------------------------------------------------
module khws_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_valid,
	input  khws_pkg::hash_t                 q_data,
	output logic                            q_pop,
	input  logic [khws_pkg::WC_W-1:0]       worker_count,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [khws_pkg::OUT_W-1:0]      out_data,
	output khws_pkg::back_status_t          status
);

	khws_pkg::back_state_t           state_q;
	khws_pkg::back_state_t           state_d;
	khws_pkg::hash_t                 hash_q;
	logic [khws_pkg::WC_W-1:0]       rem_q;
	logic [khws_pkg::WC_W-1:0]       count_q;
	logic [khws_pkg::BIT_W-1:0]      bit_q;
	logic                            out_valid_q;
	logic [khws_pkg::IDX_W-1:0]      out_index_q;
	khws_pkg::hash_t                 out_hash_q;
	logic [khws_pkg::WC_W:0]         rem_shift;
	logic [khws_pkg::WC_W:0]         rem_sub;
	logic [khws_pkg::WC_W-1:0]       rem_next;
	logic                            load;

	// restoring step: bring in one hash bit, subtract the count if it fits
	assign rem_shift = {rem_q, hash_q[bit_q]};
	assign rem_sub   = rem_shift - {1'b0, count_q};
	assign rem_next  = (rem_shift >= {1'b0, count_q}) ? rem_sub[khws_pkg::WC_W-1:0]
	                                                  : rem_shift[khws_pkg::WC_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= khws_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		load    = 1'b0;
		case (state_q)
			khws_pkg::BK_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = khws_pkg::BK_FIN;
				end
			end
			khws_pkg::BK_FIN: begin
				state_d = khws_pkg::BK_DIV;
			end
			khws_pkg::BK_DIV: begin
				if (bit_q == '0) begin
					state_d = khws_pkg::BK_DONE;
				end
			end
			khws_pkg::BK_DONE: begin
				if (!out_valid_q || out_ready) begin
					load    = 1'b1;
					state_d = khws_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = khws_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			khws_pkg::BK_IDLE: begin
				hash_q <= q_data;
			end
			khws_pkg::BK_FIN: begin
				hash_q  <= khws_pkg::final_mix(hash_q);
				rem_q   <= '0;
				bit_q   <= khws_pkg::BIT_W'(khws_pkg::HASH_W - 1);
				count_q <= khws_pkg::eff_count(worker_count);
			end
			khws_pkg::BK_DIV: begin
				rem_q <= rem_next;
				bit_q <= bit_q - 1'b1;
			end
			default: begin
				hash_q <= hash_q;
			end
		endcase
		if (load) begin
			out_index_q <= rem_q[khws_pkg::IDX_W-1:0];
			out_hash_q  <= hash_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_data     = {out_hash_q, out_index_q};
	assign status.busy  = (state_q == khws_pkg::BK_DIV);
	assign status.rem   = rem_q;
	assign status.count = count_q;

endmodule

/* hdl/key_hash_worker_select.sv */
// Intake takes one byte per cycle while the two-entry queue has room.
// The back end takes one key at a time and runs the one-bit-per-cycle modulo loop,
// so for short keys the result rate is set by the back end, not by the intake.
// Reset clears the running hash, the queue, the back end and sets worker count to 1.
// ----------------------------------------------------------------------------
// key_hash_worker_select: one-at-a-time key hash with worker selection
// Byte-serial hash of a key, final mix, and hash modulo the worker count.
// ----------------------------------------------------------------------------
module key_hash_worker_select (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [khws_pkg::BYTE_W-1:0]      s_axis_tdata,  // [7:0] key_byte
	input  logic                             s_axis_tlast,  // last_byte
	input  logic                             s_axis_tuser,  // empty_key
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [khws_pkg::OUT_W-1:0]       m_axis_tdata,  // [7:0] worker_index,
	                                                        // [39:8] key_digest
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [khws_pkg::WC_W-1:0]        cfg_data       // worker_count
);

	logic [khws_pkg::WC_W-1:0] worker_count_q;
	logic                      q_push;
	logic                      q_full;
	logic                      q_pop;
	logic                      q_valid;
	khws_pkg::hash_t           q_push_data;
	khws_pkg::hash_t           q_pop_data;
	khws_pkg::back_status_t    back_status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			worker_count_q <= khws_pkg::WC_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			worker_count_q <= cfg_data;
		end
	end

	khws_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.key_byte  (s_axis_tdata),
		.last_byte (s_axis_tlast),
		.empty_key (s_axis_tuser),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_push_data)
	);

	khws_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (q_pop_data)
	);

	khws_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_data       (q_pop_data),
		.q_pop        (q_pop),
		.worker_count (worker_count_q),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_data     (m_axis_tdata),
		.status       (back_status)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("push into a full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from an empty queue");

	a_rem_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		back_status.busy |-> (back_status.rem < back_status.count))
		else $error("remainder not below worker count");

	a_zero_hash_index: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tdata[khws_pkg::OUT_W-1:khws_pkg::IDX_W] == '0))
		|-> (m_axis_tdata[khws_pkg::IDX_W-1:0] == '0))
		else $error("zero hash with nonzero worker index");

endmodule

/* test/key_hash_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_hash_checker: result predictor and scoreboard for key_hash_worker_select
// Watches the key, result and worker count channels, computes the expected
// hash and worker for every finished key and compares each result word.
// ----------------------------------------------------------------------------
module key_hash_checker
	import khws_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [BYTE_W-1:0]     s_axis_tdata,   // [7:0] key_byte
	input  logic                  s_axis_tlast,   // last_byte
	input  logic                  s_axis_tuser,   // empty_key
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_W-1:0]      m_axis_tdata,   // [7:0] worker_index, [39:8] key_digest
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [WC_W-1:0]       cfg_data,       // worker_count
	output int unsigned           fail_count,
	output int unsigned           outstanding
);

	typedef struct packed {
		logic [IDX_W-1:0] worker;
		hash_t            hash;
	} selection_t;

	selection_t       pending_selections[$];
	logic [WC_W-1:0]  workers_cfg;
	hash_t            key_acc;
	hash_t            key_hash;
	selection_t       got;
	selection_t       want;

	function automatic hash_t absorb_byte(input hash_t acc, input logic [BYTE_W-1:0] b);
		hash_t t;
		t = acc + hash_t'(b);
		t = t + (t << 10);
		t = t ^ (t >> 6);
		return t;
	endfunction

	function automatic hash_t finish_hash(input hash_t acc);
		hash_t t;
		t = acc + (acc << 3);
		t = t ^ (t >> 11);
		t = t + (t << 15);
		return t;
	endfunction

	function automatic selection_t select_worker(input hash_t h, input logic [WC_W-1:0] wc);
		int unsigned n;
		selection_t  sel;
		n = wc;
		// zero acts as one worker, anything above the maximum saturates
		if (n == 0) begin
			n = 1;
		end
		if (n > MAX_WORKERS) begin
			n = MAX_WORKERS;
		end
		sel.hash   = h;
		sel.worker = IDX_W'(h % n);
		return sel;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			workers_cfg = WC_W'(1);
			key_acc     = '0;
			pending_selections.delete();
			fail_count  = 0;
			outstanding = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = selection_t'({m_axis_tdata[IDX_W-1:0], m_axis_tdata[OUT_W-1:IDX_W]});
				if (pending_selections.size() == 0) begin
					$error("result word with none expected: worker_index %0d, key_digest %h",
						got.worker, got.hash);
					fail_count++;
				end else begin
					want = pending_selections.pop_front();
					if (got.worker !== want.worker) begin
						$error("worker_index mismatch: expected %0d, actual %0d",
							want.worker, got.worker);
						fail_count++;
					end
					if (got.hash !== want.hash) begin
						$error("key_digest mismatch: expected %h, actual %h",
							want.hash, got.hash);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				workers_cfg = cfg_data;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser) begin
					// drop whatever was mixed in so far
					key_acc = '0;
					pending_selections.push_back(select_worker(finish_hash('0), workers_cfg));
				end else begin
					key_acc = absorb_byte(key_acc, s_axis_tdata);
					if (s_axis_tlast) begin
						key_hash = finish_hash(key_acc);
						key_acc  = '0;
						pending_selections.push_back(select_worker(key_hash, workers_cfg));
					end
				end
			end
			outstanding = pending_selections.size();
		end
	end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus for key_hash_worker_select
// Sends directed and random keys under several worker counts with random
// gaps and stalls on both streams; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
	import khws_pkg::*;

	localparam int unsigned RANDOM_WORDS = 1700;
	localparam int unsigned SETTLE       = 40;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [BYTE_W-1:0]  s_axis_tdata;    // [7:0] key_byte
	logic               s_axis_tlast;    // last_byte
	logic               s_axis_tuser;    // empty_key
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [OUT_W-1:0]   m_axis_tdata;    // [7:0] worker_index, [39:8] key_digest
	logic               cfg_valid;
	logic               cfg_ready;
	logic [WC_W-1:0]    cfg_data;        // worker_count

	int unsigned        fail_count;
	int unsigned        outstanding;
	int unsigned        words_sent;
	int unsigned        hold_off_seq;
	bit                 src_calm;
	bit                 sink_calm;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	key_hash_worker_select dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	key_hash_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.outstanding   (outstanding)
	);

	function automatic int unsigned pick_gap(input bit calm);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 65) begin
			return 0;
		end else if (r < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [BYTE_W-1:0] pick_byte();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			return 8'h00;
		end else if (r < 20) begin
			return 8'hFF;
		end
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic put_word(input logic [BYTE_W-1:0] b, input logic last, input logic empty);
		int unsigned gap;
		gap = pick_gap(src_calm);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = b;
		s_axis_tlast  = last;
		s_axis_tuser  = empty;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_key(input int unsigned len);
		int unsigned i;
		for (i = 0; i < len; i++) begin
			put_word(pick_byte(), i == len - 1, 1'b0);
		end
	endtask

	task automatic send_random_key();
		int unsigned r;
		int unsigned len;
		int unsigned i;
		r = $urandom_range(0, 99);
		len = (r < 90) ? $urandom_range(1, 8) : $urandom_range(9, 40);
		if (r < 6) begin
			put_word(pick_byte(), 1'($urandom_range(0, 1)), 1'b1);
		end else if (r >= 96) begin
			// abandon a key part way with an empty-key word
			for (i = 0; i < len; i++) begin
				put_word(pick_byte(), 1'b0, 1'b0);
			end
			put_word(pick_byte(), 1'($urandom_range(0, 1)), 1'b1);
		end else begin
			send_key(len);
		end
	endtask

	task automatic wait_drained();
		s_axis_tvalid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_workers(input logic [WC_W-1:0] wc);
		cfg_valid = 1'b1;
		cfg_data  = wc;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// result side: random stalls, plus a long hold whenever hold_off_seq moves
	initial begin
		int unsigned stall_left;
		int unsigned seen_seq;
		int unsigned r;
		stall_left    = 0;
		seen_seq      = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (seen_seq != hold_off_seq) begin
				seen_seq   = hold_off_seq;
				stall_left = 400;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready = 1'b0;
			end else if (sink_calm) begin
				m_axis_tready = 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					m_axis_tready = 1'b1;
				end else begin
					m_axis_tready = 1'b0;
					stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(9, 39);
				end
			end
		end
	end

	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		int unsigned   phase;
		int unsigned   i;
		logic [WC_W-1:0] wc;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		s_axis_tuser  = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		words_sent    = 0;
		hold_off_seq  = 0;
		src_calm      = 1'b0;
		sink_calm     = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset worker count of one: empty keys, single bytes, abandoned key
		put_word(8'hFF, 1'b1, 1'b1);
		put_word(8'h00, 1'b0, 1'b1);
		put_word(8'h00, 1'b1, 1'b0);
		put_word(8'hFF, 1'b1, 1'b0);
		put_word(8'h12, 1'b0, 1'b0);
		put_word(8'h34, 1'b0, 1'b0);
		put_word(8'h56, 1'b0, 1'b1);
		put_word(8'h80, 1'b0, 1'b0);
		put_word(8'h7F, 1'b1, 1'b0);
		wait_drained();

		write_workers(WC_W'(MAX_WORKERS));
		put_word(8'hFF, 1'b0, 1'b0);
		put_word(8'h00, 1'b0, 1'b0);
		put_word(8'hA5, 1'b1, 1'b0);
		put_word(8'h01, 1'b1, 1'b0);
		put_word(8'h3C, 1'b1, 1'b1);
		wait_drained();

		// zero behaves as one worker
		write_workers('0);
		put_word(8'hFF, 1'b1, 1'b0);
		put_word(8'h55, 1'b0, 1'b0);
		put_word(8'hAA, 1'b1, 1'b0);
		wait_drained();

		// above the maximum saturates
		write_workers('1);
		for (i = 0; i < 4; i++) begin
			put_word(8'hFF, i == 3, 1'b0);
		end
		wait_drained();
		write_workers(WC_W'(MAX_WORKERS + 1));
		put_word(8'hC3, 1'b1, 1'b0);
		wait_drained();

		words_sent = 0;
		phase = 0;
		while (words_sent < RANDOM_WORDS) begin
			case (phase % 10)
				0: begin wc = WC_W'(1); end
				1: begin wc = WC_W'(MAX_WORKERS); end
				2: begin wc = '0; end
				3: begin wc = '1; end
				4: begin wc = WC_W'(MAX_WORKERS + 1); end
				5: begin wc = WC_W'(3); end
				6: begin wc = WC_W'(MAX_WORKERS - 1); end
				default: begin wc = WC_W'($urandom_range(2, 511)); end
			endcase
			write_workers(wc);
			src_calm  = ($urandom_range(0, 3) == 0);
			sink_calm = ($urandom_range(0, 3) == 0);
			if (phase == 1 || $urandom_range(0, 4) == 0) begin
				// hold results off while short keys pile up at full rate
				src_calm = 1'b1;
				hold_off_seq++;
				for (i = 0; i < 30; i++) begin
					send_key($urandom_range(1, 2));
				end
				src_calm = 1'b0;
			end
			for (i = 0; i < 40; i++) begin
				send_random_key();
			end
			wait_drained();
			phase++;
		end

		wait_drained();
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

/* key_hash_worker_select.f */
hdl/khws_pkg.sv
hdl/khws_front.sv
hdl/khws_queue.sv
hdl/khws_back.sv
hdl/key_hash_worker_select.sv
test/key_hash_checker.sv
test/tb.sv
